>>> hw/rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the clamped PID controller
// Widths of the datapath, controller states, multiplier operand selects and
// the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  // field and datapath widths
  localparam int DATA_W    = 32;  // measured, time, gains
  localparam int ERR_W     = 33;  // setpoint minus measured
  localparam int DIFF_W    = 34;  // error minus previous error
  localparam int QUO_W     = 33;  // derivative magnitude
  localparam int INTEG_W   = 64;  // integral accumulator
  localparam int PROD_W    = 64;  // one 32x32 partial product
  localparam int ACC_W     = 97;  // exact sum of the three terms
  localparam int DRIVE_W   = 8;
  localparam int LEVEL_W   = 7;   // magnitude of the clamped drive
  localparam int DIV_STEPS = 33;  // one quotient bit per step
  localparam int DIV_CNT_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] DRIVE_MAX = 7'd100;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET     = 2'd0,
    REG_PROP_GAIN  = 2'd1,
    REG_INTEG_GAIN = 2'd2,
    REG_DERIV_GAIN = 2'd3
  } cfg_reg_t;

  // configuration values, each signed Q16.16 in two's complement
  typedef struct packed {
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] prop;
    logic [DATA_W-1:0] integ;
    logic [DATA_W-1:0] deriv;
  } pidc_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MUL_ED,
    S_MUL_P,
    S_MUL_IL,
    S_MUL_IH,
    S_MUL_DL,
    S_MUL_DH,
    S_DRAIN,
    S_FINISH
  } state_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ED,   // |error| * dt, for the integral
    MUL_P,    // |Kp| * |error|
    MUL_IL,   // |Ki| * |integral| low half
    MUL_IH,   // |Ki| * |integral| high half
    MUL_DL,   // |Kd| * |derivative| low half
    MUL_DH    // |Kd| * |derivative| high bit
  } mul_sel_t;

  typedef struct packed {
    logic     load;      // take the input word, update stored time and error
    logic     div_step;  // one restoring divider step
    mul_sel_t mul_sel;
    logic     finish;    // truncate, clamp and load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;  // first step or zero interval: no derivative, no integration
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/pid_controller_clamped_core.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_core: PID controller with clamped integer drive
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each input word carries a signed Q16.16 measurement and a millisecond time
// stamp; each produces one output word holding the drive value, an integer
// clamped to [-100, 100]. A step whose stored time is zero counts as the first
// one and neither differentiates nor integrates; a zero interval likewise
// gives a zero derivative. The integral saturates at the signed 64-bit bounds.
// The serial restoring divider forms the derivative, one bit per cycle (it
// is skipped on a first step or zero interval); six products follow on the
// one shared 32x32 multiplier, the last is drained into the accumulator,
// and the sum is truncated and clamped into the output register. The next
// word is accepted while the result waits in the output register. Gains and
// setpoint are to be written only while the block is idle, which the block
// itself does not enforce; reset clears them, the stored time, error and integral.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,    // [31:0] measured, [63:32] time_ms
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,   // [7:0] drive
  // configuration writes
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_wdata
);

  pidc_pkg::pidc_cfg_t  cfg_r;
  pidc_pkg::ctrl_cmd_t  cmd;
  pidc_pkg::dp_status_t status;

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (pidc_pkg::cfg_reg_t'(cfg_index))
        pidc_pkg::REG_TARGET:     cfg_r.target <= cfg_wdata;
        pidc_pkg::REG_PROP_GAIN:  cfg_r.prop   <= cfg_wdata;
        pidc_pkg::REG_INTEG_GAIN: cfg_r.integ  <= cfg_wdata;
        pidc_pkg::REG_DERIV_GAIN: cfg_r.deriv  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  pidc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  pidc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg         (cfg_r),
    .in_measured (in_tdata[31:0]),
    .in_time     (in_tdata[63:32]),
    .drive       (out_tdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pidc_ctrl.sv
// ----------------------------------------------------------------------------
// pidc_ctrl: sequencer of the clamped PID controller
// Steps the serial divider, walks the multiplier through its six products
// and hands the finished drive word to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  pidc_pkg::dp_status_t status,
  output pidc_pkg::ctrl_cmd_t  cmd
);

  pidc_pkg::state_t               state_r, state_nxt;
  logic [pidc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidc_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == pidc_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.mul_sel  = pidc_pkg::MUL_NONE;
    cmd.finish   = 1'b0;
    case (state_r)
      pidc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = pidc_pkg::S_DIV;
        end
      end
      pidc_pkg::S_DIV: begin
        if (status.skip) begin
          state_nxt = pidc_pkg::S_MUL_ED;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS - 1)) begin
            state_nxt = pidc_pkg::S_MUL_ED;
          end
        end
      end
      pidc_pkg::S_MUL_ED: begin
        cmd.mul_sel = pidc_pkg::MUL_ED;
        state_nxt   = pidc_pkg::S_MUL_P;
      end
      pidc_pkg::S_MUL_P: begin
        cmd.mul_sel = pidc_pkg::MUL_P;
        state_nxt   = pidc_pkg::S_MUL_IL;
      end
      pidc_pkg::S_MUL_IL: begin
        cmd.mul_sel = pidc_pkg::MUL_IL;
        state_nxt   = pidc_pkg::S_MUL_IH;
      end
      pidc_pkg::S_MUL_IH: begin
        cmd.mul_sel = pidc_pkg::MUL_IH;
        state_nxt   = pidc_pkg::S_MUL_DL;
      end
      pidc_pkg::S_MUL_DL: begin
        cmd.mul_sel = pidc_pkg::MUL_DL;
        state_nxt   = pidc_pkg::S_MUL_DH;
      end
      pidc_pkg::S_MUL_DH: begin
        cmd.mul_sel = pidc_pkg::MUL_DH;
        state_nxt   = pidc_pkg::S_DRAIN;
      end
      pidc_pkg::S_DRAIN: begin
        // last product lands in the accumulator
        state_nxt = pidc_pkg::S_FINISH;
      end
      pidc_pkg::S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = pidc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pidc_pkg::S_IDLE;
      end
    endcase
  end

  // output word valid: set on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pidc_datapath.sv
// ----------------------------------------------------------------------------
// pidc_datapath: arithmetic of the clamped PID controller
// Error and interval capture, serial restoring divider, shared 32x32
// magnitude multiplier, saturating integral, exact accumulator and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  pidc_pkg::ctrl_cmd_t                cmd,
  output pidc_pkg::dp_status_t               status,
  input  pidc_pkg::pidc_cfg_t                cfg,
  input  wire  [pidc_pkg::DATA_W-1:0]        in_measured,
  input  wire  [pidc_pkg::DATA_W-1:0]        in_time,
  output logic [pidc_pkg::DRIVE_W-1:0]       drive
);

  localparam int SH = 2 * FRAC_BITS;

  // two's complement magnitudes
  function automatic logic [pidc_pkg::DATA_W-1:0] mag32(input logic [pidc_pkg::DATA_W-1:0] v);
    mag32 = v[pidc_pkg::DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [pidc_pkg::INTEG_W-1:0] mag64(
    input logic [pidc_pkg::INTEG_W-1:0] v);
    mag64 = v[pidc_pkg::INTEG_W-1] ? (~v + 1'b1) : v;
  endfunction

  // stored controller state
  logic [pidc_pkg::DATA_W-1:0]  last_time_r;
  logic [pidc_pkg::ERR_W-1:0]   prev_err_r;
  logic [pidc_pkg::INTEG_W-1:0] integ_r, integ_nxt;

  // per-item working registers
  logic [pidc_pkg::DATA_W-1:0]  emag_r;
  logic                         eneg_r;
  logic [pidc_pkg::DATA_W-1:0]  dt_r;
  logic                         dneg_r;
  logic                         skip_r;
  logic [pidc_pkg::QUO_W-1:0]   quo_r;
  logic [pidc_pkg::DATA_W-1:0]  rem_r;
  logic [pidc_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [pidc_pkg::DRIVE_W-1:0] drive_r, drive_nxt;

  // multiplier stage
  logic [pidc_pkg::PROD_W-1:0]  prod_r;
  pidc_pkg::mul_sel_t           tag_r;
  logic                         pneg_r;
  logic                         phi_r;

  // capture arithmetic
  logic [pidc_pkg::ERR_W-1:0]   err;
  logic [pidc_pkg::DIFF_W-1:0]  diff;
  logic [pidc_pkg::DIFF_W-1:0]  diff_mag;
  logic [pidc_pkg::DATA_W-1:0]  dt;
  logic [pidc_pkg::ERR_W-1:0]   err_mag;

  assign err = {cfg.target[pidc_pkg::DATA_W-1], cfg.target}
             - {in_measured[pidc_pkg::DATA_W-1], in_measured};
  assign diff = {err[pidc_pkg::ERR_W-1], err}
              - {prev_err_r[pidc_pkg::ERR_W-1], prev_err_r};
  assign diff_mag = diff[pidc_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign err_mag  = err[pidc_pkg::ERR_W-1] ? (~err + 1'b1) : err;
  assign dt       = in_time - last_time_r;

  assign status.skip = skip_r;

  // divider step: shift in one dividend bit, subtract when it fits
  logic [pidc_pkg::DATA_W:0]    rem_sh;
  logic [pidc_pkg::DATA_W:0]    rem_sub;
  logic                         fits;

  assign rem_sh  = {rem_r, quo_r[pidc_pkg::QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, dt_r};
  assign fits    = (rem_sh >= {1'b0, dt_r});

  // capture, divide and stored state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      prev_err_r  <= '0;
      integ_r     <= '0;
    end else begin
      integ_r <= integ_nxt;
      if (cmd.load) begin
        last_time_r <= in_time;
        prev_err_r  <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      emag_r <= err_mag[pidc_pkg::DATA_W-1:0];
      eneg_r <= err[pidc_pkg::ERR_W-1];
      dt_r   <= dt;
      dneg_r <= diff[pidc_pkg::DIFF_W-1];
      skip_r <= (last_time_r == '0) || (dt == '0);
      quo_r  <= diff_mag[pidc_pkg::QUO_W-1:0];
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[pidc_pkg::QUO_W-2:0], fits};
      rem_r <= fits ? rem_sub[pidc_pkg::DATA_W-1:0] : rem_sh[pidc_pkg::DATA_W-1:0];
    end
  end

  // operand selection for the shared multiplier
  logic [pidc_pkg::QUO_W-1:0]   dmag;
  logic [pidc_pkg::INTEG_W-1:0] imag;
  logic [pidc_pkg::DATA_W-1:0]  mul_a, mul_b;
  logic                         mul_neg, mul_hi;

  assign dmag = skip_r ? '0 : quo_r;
  assign imag = mag64(integ_r);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_hi  = 1'b0;
    case (cmd.mul_sel)
      pidc_pkg::MUL_ED: begin
        mul_a   = emag_r;
        mul_b   = dt_r;
        mul_neg = eneg_r;
      end
      pidc_pkg::MUL_P: begin
        mul_a   = mag32(cfg.prop);
        mul_b   = emag_r;
        mul_neg = cfg.prop[pidc_pkg::DATA_W-1] ^ eneg_r;
      end
      pidc_pkg::MUL_IL: begin
        mul_a   = mag32(cfg.integ);
        mul_b   = imag[pidc_pkg::DATA_W-1:0];
        mul_neg = cfg.integ[pidc_pkg::DATA_W-1] ^ integ_r[pidc_pkg::INTEG_W-1];
      end
      pidc_pkg::MUL_IH: begin
        mul_a   = mag32(cfg.integ);
        mul_b   = imag[pidc_pkg::INTEG_W-1:pidc_pkg::DATA_W];
        mul_neg = cfg.integ[pidc_pkg::DATA_W-1] ^ integ_r[pidc_pkg::INTEG_W-1];
        mul_hi  = 1'b1;
      end
      pidc_pkg::MUL_DL: begin
        mul_a   = mag32(cfg.deriv);
        mul_b   = dmag[pidc_pkg::DATA_W-1:0];
        mul_neg = cfg.deriv[pidc_pkg::DATA_W-1] ^ dneg_r;
      end
      pidc_pkg::MUL_DH: begin
        mul_a   = mag32(cfg.deriv);
        mul_b   = {{(pidc_pkg::DATA_W-1){1'b0}}, dmag[pidc_pkg::QUO_W-1]};
        mul_neg = cfg.deriv[pidc_pkg::DATA_W-1] ^ dneg_r;
        mul_hi  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // register the product with its tag, sign and weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= pidc_pkg::MUL_NONE;
    end else begin
      tag_r <= cmd.mul_sel;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    pneg_r <= mul_neg;
    phi_r  <= mul_hi;
  end

  // saturating integral update from |error| * dt
  logic [pidc_pkg::INTEG_W+1:0] ed_term;
  logic [pidc_pkg::INTEG_W+1:0] isum;

  assign ed_term = {2'b00, prod_r};
  assign isum    = {{2{integ_r[pidc_pkg::INTEG_W-1]}}, integ_r}
                 + (pneg_r ? (~ed_term + 1'b1) : ed_term);

  always_comb begin
    integ_nxt = integ_r;
    if (tag_r == pidc_pkg::MUL_ED && !skip_r) begin
      if (isum[pidc_pkg::INTEG_W+1:pidc_pkg::INTEG_W-1] inside {3'b000, 3'b111}) begin
        integ_nxt = isum[pidc_pkg::INTEG_W-1:0];
      end else if (isum[pidc_pkg::INTEG_W+1]) begin
        integ_nxt = {1'b1, {(pidc_pkg::INTEG_W-1){1'b0}}};
      end else begin
        integ_nxt = {1'b0, {(pidc_pkg::INTEG_W-1){1'b1}}};
      end
    end
  end

  // exact accumulation of the gain terms
  logic [pidc_pkg::ACC_W-1:0] term;

  assign term = phi_r ? {1'b0, prod_r, {pidc_pkg::DATA_W{1'b0}}}
                      : {{(pidc_pkg::ACC_W-pidc_pkg::PROD_W){1'b0}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load) begin
      acc_nxt = '0;
    end else if (!(tag_r inside {pidc_pkg::MUL_NONE, pidc_pkg::MUL_ED})) begin
      acc_nxt = pneg_r ? (acc_r - term) : (acc_r + term);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // truncate toward zero, clamp and restore the sign
  logic                         acc_neg;
  logic [pidc_pkg::ACC_W-1:0]   acc_mag;
  logic [pidc_pkg::ACC_W-1:0]   acc_int;
  logic [pidc_pkg::LEVEL_W-1:0] level;
  logic [pidc_pkg::DRIVE_W-1:0] drv_mag;

  assign acc_neg = acc_r[pidc_pkg::ACC_W-1];
  assign acc_mag = acc_neg ? (~acc_r + 1'b1) : acc_r;
  assign acc_int = acc_mag >> SH;
  assign level   = (acc_int > pidc_pkg::ACC_W'(pidc_pkg::DRIVE_MAX))
                 ? pidc_pkg::DRIVE_MAX : acc_int[pidc_pkg::LEVEL_W-1:0];
  assign drv_mag = {1'b0, level};

  always_comb begin
    drive_nxt = drive_r;
    if (cmd.finish) begin
      drive_nxt = acc_neg ? (~drv_mag + 1'b1) : drv_mag;
    end
  end

  always_ff @(posedge clk) begin
    drive_r <= drive_nxt;
  end

  assign drive = drive_r;

endmodule

`default_nettype wire
